// ----- rtl/efzt_pkg.sv -----
// shared constants for the encoder floor zone tracker
package efzt_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int FLOOR_LIMIT = 31;
  localparam int FLOOR_W     = $clog2(TABLE_DEPTH);
  localparam int POS_W       = 32;
  localparam int ACC_W       = POS_W + 1;

  // the walk never leaves the table
  localparam int WALK_LIM_INT = (FLOOR_LIMIT > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : FLOOR_LIMIT;
  localparam logic [FLOOR_W-1:0] WALK_LIM = FLOOR_W'(WALK_LIM_INT);

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;

  typedef logic [FLOOR_W-1:0] floor_t;
  typedef logic [ACC_W-1:0]   acc_t;

endpackage

// ----- rtl/efzt_ram.sv -----
// generic one-write one-read ram with registered read data
module efzt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/encoder_floor_zone_tracker_unit.sv -----
// top level of the encoder floor zone tracker
//
// input channel (in_valid / in_stall): a table-write item (in_command high)
// stores in_entry_position at in_entry_index, no result. a
// sample item walks the floor level table from the kept floor and gives one
// result item; a sample with in_learning high is dropped, no state change.
// result channel (out_valid / out_stall): out_floor and out_selector_code
// (floor doubled) sit in an output register until taken.
// a sample reads entries 0 and 1 (level direction) and the level of the kept
// floor, walks past each level crossed, then runs the midpoint check, which a
// walk that ends at the first or last floor skips. one registered table read
// per floor step and one shared 33-bit add/subtract unit serve every compare
// and the midpoint sum. throughput: in_stall is high while a sample is worked
// on, the next item is taken in the cycle after its result is registered;
// table writes are taken every cycle while idle, even while a result waits
// in the output register. if the receiver stalls, a finished sample waits in
// its last step. reset (rst_n, synchronous, active low): kept floor 0,
// top_floor 31, output empty; the table ram is not cleared. the user must
// write entries before they are read, and write top_floor (cfg_wr_en /
// cfg_wr_data) only while the block is idle; the block enforces neither.
module encoder_floor_zone_tracker_unit
  import efzt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [FLOOR_W-1:0]  cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_command,
  input  logic signed [31:0]  in_position,
  input  logic                in_learning,
  input  logic [4:0]          in_entry_index,
  input  logic signed [31:0]  in_entry_position,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [4:0]          out_floor,
  output logic [5:0]          out_selector_code
);

  // sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;  // waiting for an item
  localparam logic [3:0] S_RD0  = 4'd1;  // entry 0 arrives
  localparam logic [3:0] S_RD1  = 4'd2;  // entry 1 arrives, direction found
  localparam logic [3:0] S_RDF  = 4'd3;  // level of kept floor arrives
  localparam logic [3:0] S_WALK = 4'd4;  // one neighbor level per cycle
  localparam logic [3:0] S_SUM  = 4'd5;  // sum of the two levels
  localparam logic [3:0] S_RND  = 4'd6;  // round sum toward zero, halve
  localparam logic [3:0] S_CMP  = 4'd7;  // position against midpoint
  localparam logic [3:0] S_FIN  = 4'd8;  // clamp and hand to output

  logic [3:0]  state_r, state_nxt;
  floor_t      floor_now_r, floor_now_nxt;
  floor_t      top_floor_r, top_floor_nxt;
  floor_t      f_r, f_nxt;
  logic        up_r, up_nxt;           // levels count up with floor
  logic        walk_up_r, walk_up_nxt; // walking toward higher floors
  logic        out_valid_r, out_valid_nxt;
  floor_t      out_floor_r, out_floor_nxt;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] cur_r, cur_nxt;    // level of floor f
  logic [POS_W-1:0] nb_r, nb_nxt;      // level of the neighbor floor
  acc_t             acc_r, acc_nxt;    // midpoint sum, then midpoint

  // table ram
  logic             ram_we;
  floor_t           ram_raddr;
  logic [POS_W-1:0] ram_rdata;

  // shared add/subtract unit
  acc_t alu_a, alu_b, alu_res;
  logic alu_sub, alu_cin;
  logic alu_neg, alu_zero, alu_gt, alu_lt;

  logic   accept;
  logic   out_free;
  logic   want_gt, crossed;
  logic   rdf_walk_up;
  floor_t f_start, f_adv, f_adv2, f_clamp;
  floor_t bound;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign ram_we   = accept && (in_command == CMD_WRITE);
  assign out_free = !out_valid_r || !out_stall;

  efzt_ram #(
    .WIDTH(POS_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(in_entry_index),
    .wr_data(in_entry_position),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  assign alu_res  = alu_a + (alu_sub ? ~alu_b : alu_b) + {{(ACC_W-1){1'b0}}, alu_cin};
  assign alu_neg  = alu_res[ACC_W-1];
  assign alu_zero = (alu_res == '0);
  assign alu_gt   = !alu_neg && !alu_zero;
  assign alu_lt   = alu_neg;

  // operand select per step
  always_comb begin
    alu_a   = {pos_r[POS_W-1], pos_r};
    alu_b   = {ram_rdata[POS_W-1], ram_rdata};
    alu_sub = 1'b1;
    alu_cin = 1'b1;
    unique case (state_r)
      S_RD1: begin
        alu_a = {ram_rdata[POS_W-1], ram_rdata};
        alu_b = {cur_r[POS_W-1], cur_r};
      end
      S_SUM: begin
        alu_a   = {cur_r[POS_W-1], cur_r};
        alu_b   = {nb_r[POS_W-1], nb_r};
        alu_sub = 1'b0;
        alu_cin = 1'b0;
      end
      S_RND: begin
        alu_a   = acc_r;
        alu_b   = '0;
        alu_sub = 1'b0;
        alu_cin = acc_r[ACC_W-1];  // negative sum rounds toward zero
      end
      S_CMP: begin
        alu_b = acc_r;
      end
      default: begin
      end
    endcase
  end

  // level ordering and walk direction decide which side counts as crossed
  assign want_gt     = (up_r == walk_up_r);
  assign crossed     = want_gt ? alu_gt : alu_lt;
  assign rdf_walk_up = up_r ? !alu_neg : (alu_neg || alu_zero);

  assign f_start = (floor_now_r > WALK_LIM) ? WALK_LIM : floor_now_r;
  assign f_adv   = walk_up_r ? f_r + FLOOR_W'(1) : f_r - FLOOR_W'(1);
  assign f_adv2  = walk_up_r ? f_r + FLOOR_W'(2) : f_r - FLOOR_W'(2);
  assign bound   = walk_up_r ? WALK_LIM : '0;
  assign f_clamp = (f_r > top_floor_r) ? top_floor_r : f_r;

  always_comb begin
    state_nxt     = state_r;
    floor_now_nxt = floor_now_r;
    top_floor_nxt = top_floor_r;
    f_nxt         = f_r;
    up_nxt        = up_r;
    walk_up_nxt   = walk_up_r;
    out_valid_nxt = out_valid_r;
    out_floor_nxt = out_floor_r;
    pos_nxt       = pos_r;
    cur_nxt       = cur_r;
    nb_nxt        = nb_r;
    acc_nxt       = acc_r;
    ram_raddr     = f_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_wr_en) begin
      top_floor_nxt = cfg_wr_data;
    end

    unique case (state_r)
      S_IDLE: begin
        ram_raddr = '0;
        if (accept && (in_command == CMD_SAMPLE) && !in_learning) begin
          pos_nxt   = in_position;
          state_nxt = S_RD0;
        end
      end
      S_RD0: begin
        ram_raddr = FLOOR_W'(1);
        cur_nxt   = ram_rdata;
        state_nxt = S_RD1;
      end
      S_RD1: begin
        ram_raddr = f_start;
        up_nxt    = !alu_neg;
        f_nxt     = f_start;
        state_nxt = S_RDF;
      end
      S_RDF: begin
        cur_nxt     = ram_rdata;
        walk_up_nxt = rdf_walk_up;
        ram_raddr   = rdf_walk_up ? f_r + FLOOR_W'(1) : f_r - FLOOR_W'(1);
        if (rdf_walk_up ? (f_r == WALK_LIM) : (f_r == '0)) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        ram_raddr = f_adv2;
        if (crossed) begin
          f_nxt   = f_adv;
          cur_nxt = ram_rdata;
          if (f_adv == bound) begin
            state_nxt = S_FIN;
          end
        end else begin
          nb_nxt    = ram_rdata;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        acc_nxt   = alu_res;
        state_nxt = S_RND;
      end
      S_RND: begin
        acc_nxt   = {alu_res[ACC_W-1], alu_res[ACC_W-1:1]};
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (crossed) begin
          f_nxt = f_adv;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          floor_now_nxt = f_clamp;
          out_floor_nxt = f_clamp;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      floor_now_r <= '0;
      top_floor_r <= FLOOR_W'(31);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      floor_now_r <= floor_now_nxt;
      top_floor_r <= top_floor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    f_r         <= f_nxt;
    up_r        <= up_nxt;
    walk_up_r   <= walk_up_nxt;
    out_floor_r <= out_floor_nxt;
    pos_r       <= pos_nxt;
    cur_r       <= cur_nxt;
    nb_r        <= nb_nxt;
    acc_r       <= acc_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_floor         = out_floor_r;
  assign out_selector_code = {out_floor_r, 1'b0};

endmodule

// ----- tb/tb.sv -----
// testbench for encoder_floor_zone_tracker_unit: directed plan, random phases, floor predictor
`timescale 1ns / 1ps

module tb
  import efzt_pkg::*;
;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 48;    // covers the longest sample walk, plus margin
  localparam int PHASE_ITEMS   = 95;
  localparam longint SPAN_STEP = 138547332;  // about 2^32 / 31, spreads levels over the full range

  typedef struct {
    logic               cmd;
    logic signed [31:0] pos;
    logic               learn;
    logic [4:0]         idx;
    logic signed [31:0] epos;
  } item_t;

  // one row of the directed plan; pinned rows carry a floor known by inspection
  typedef struct {
    item_t  it;
    bit     pinned;
    floor_t pin;
  } plan_row_t;

  typedef enum int {
    LV_RISE, LV_FALL, LV_SPAN_RISE, LV_SPAN_FALL, LV_NOISE, LV_FLAT_START
  } lv_style_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [FLOOR_W-1:0] cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_command = CMD_SAMPLE;
  logic signed [31:0] in_position = '0;
  logic               in_learning = 1'b0;
  logic [4:0]         in_entry_index = '0;
  logic signed [31:0] in_entry_position = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [4:0]         out_floor;
  logic [5:0]         out_selector_code;

  encoder_floor_zone_tracker_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_position       (in_position),
    .in_learning       (in_learning),
    .in_entry_index    (in_entry_index),
    .in_entry_position (in_entry_position),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_floor         (out_floor),
    .out_selector_code (out_selector_code)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // predictor state: our own copy of the level table, kept floor and top floor
  logic signed [31:0] level_mem [TABLE_DEPTH];
  floor_t             floor_kept = '0;
  floor_t             top_sel = 5'd31;

  floor_t due[$];       // floors still owed by the block, oldest first
  int     n_bad = 0;
  int     cycles = 0;
  int     lead_gap = 0; // sender idle cycles before the next item
  int     hold_left = 0;
  bit     calm = 1'b0;  // no idling on either side while set
  floor_t exp_f;

  function automatic longint lv(input int i);
    return longint'(level_mem[i]);
  endfunction

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // walk from the kept floor past every crossed level, then the midpoint check
  function automatic floor_t locate_floor(input logic signed [31:0] pos_in);
    longint p;
    longint mid;
    int     f;
    bit     rising;
    p = longint'(pos_in);
    rising = (lv(1) - lv(0)) >= 0;
    f = floor_kept;
    if (f > WALK_LIM_INT) f = WALK_LIM_INT;
    if (rising) begin
      if (p >= lv(f)) begin
        while (f < WALK_LIM_INT) begin
          if (p > lv(f + 1)) f++;
          else begin
            mid = (lv(f) + lv(f + 1)) / 2;  // truncates toward zero
            if (p > mid) f++;
            break;
          end
        end
      end else begin
        while (f > 0) begin
          if (p < lv(f - 1)) f--;
          else begin
            mid = (lv(f) + lv(f - 1)) / 2;
            if (p < mid) f--;
            break;
          end
        end
      end
    end else begin
      // falling table: floor numbers grow as the count drops
      if (p <= lv(f)) begin
        while (f < WALK_LIM_INT) begin
          if (p < lv(f + 1)) f++;
          else begin
            mid = (lv(f) + lv(f + 1)) / 2;
            if (p < mid) f++;
            break;
          end
        end
      end else begin
        while (f > 0) begin
          if (p > lv(f - 1)) f--;
          else begin
            mid = (lv(f) + lv(f - 1)) / 2;
            if (p > mid) f--;
            break;
          end
        end
      end
    end
    if (f > top_sel) f = top_sel;
    floor_kept = floor_t'(f);
    return floor_kept;
  endfunction

  // present one item, wait for the handshake, then update the predictor
  task automatic push_item(input item_t it, input bit pinned, input floor_t pin);
    floor_t f;
    repeat (lead_gap) @(posedge clk);
    in_valid          <= 1'b1;
    in_command        <= it.cmd;
    in_position       <= it.pos;
    in_learning       <= it.learn;
    in_entry_index    <= it.idx;
    in_entry_position <= it.epos;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (it.cmd == CMD_WRITE) begin
      level_mem[it.idx] = it.epos;
    end else if (!it.learn) begin
      f = locate_floor(it.pos);
      due.push_back(pinned ? pin : f);
    end
    lead_gap = calm ? 0 : $urandom_range(0, 9);
    // lower valid now unless the next item follows back to back
    if (lead_gap != 0) in_valid <= 1'b0;
  endtask

  // hold the sender until every owed floor has come, then let the walk drain
  task automatic settle();
    // valid is already lowered when a gap was drawn
    if (lead_gap == 0) in_valid <= 1'b0;
    while (due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_top_floor(input floor_t v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    top_sel = v;
  endtask

  // rewrite all 32 levels in one of several shapes
  task automatic load_levels(input lv_style_t style);
    item_t  it;
    longint acc;
    longint first;
    int     r;
    r = $urandom;
    acc = longint'(r / 4);
    first = acc;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      case (style)
        LV_RISE, LV_FLAT_START: begin
          if (i > 0) acc += $urandom_range(1, (i % 3 == 0) ? 1000000 : 7);
          if (style == LV_FLAT_START && i == 1) acc = first;
        end
        LV_FALL: begin
          if (i > 0) acc -= $urandom_range(1, (i % 3 == 0) ? 1000000 : 7);
        end
        LV_SPAN_RISE: acc = -64'sd2147483648 + i * SPAN_STEP + $urandom_range(0, 3);
        LV_SPAN_FALL: acc = 64'sd2147483647 - i * SPAN_STEP - $urandom_range(0, 3);
        default: begin
          r = $urandom;
          acc = longint'(r);
        end
      endcase
      it.cmd   = CMD_WRITE;
      it.pos   = $urandom;
      it.learn = 1'($urandom_range(0, 1));
      it.idx   = i[4:0];
      it.epos  = clip32(acc);
      push_item(it, 1'b0, '0);
    end
  endtask

  // mostly samples near levels and midpoints, some noise and stray writes
  task automatic random_item();
    item_t it;
    int    r;
    int    k;
    it.cmd   = CMD_SAMPLE;
    it.pos   = $urandom;
    it.learn = 1'b0;
    it.idx   = 5'($urandom_range(0, 31));
    it.epos  = $urandom;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 31);
    if (r < 8) begin
      it.cmd = CMD_WRITE;
      it.learn = 1'($urandom_range(0, 1));
      if (r < 5) it.epos = clip32(lv(it.idx) + $signed($urandom_range(0, 20)) - 10);
    end else if (r < 16) begin
      it.learn = 1'b1;
    end else if (r < 24) begin
      // full random position already drawn
    end else if (r < 28) begin
      it.pos = r[0] ? 32'sh7FFFFFFF : 32'sh80000000;
    end else if (r < 64 || k == 31) begin
      it.pos = clip32(lv(k) + $signed($urandom_range(0, 4)) - 2);
    end else begin
      it.pos = clip32((lv(k) + lv(k + 1)) / 2 + $signed($urandom_range(0, 2)) - 1);
    end
    push_item(it, 1'b0, '0);
  endtask

  // directed plan, run over levels i*1000 with top floor 31
  plan_row_t plan [27] = '{
    '{'{CMD_SAMPLE, 32'sd0,          1'b0, 5'd0,  32'sd0},          1'b1, 5'd0},
    '{'{CMD_SAMPLE, 32'sh7FFFFFFF,   1'b0, 5'd0,  32'sd0},          1'b1, 5'd31},
    '{'{CMD_SAMPLE, 32'sh80000000,   1'b0, 5'd0,  32'sd0},          1'b1, 5'd0},
    '{'{CMD_SAMPLE, 32'sd5000,       1'b1, 5'd0,  32'sd0},          1'b0, 5'd0},
    '{'{CMD_SAMPLE, 32'sd5000,       1'b0, 5'd0,  32'sd0},          1'b0, 5'd0},
    '{'{CMD_SAMPLE, 32'sd5500,       1'b0, 5'd0,  32'sd0},          1'b0, 5'd0},
    '{'{CMD_SAMPLE, 32'sd5501,       1'b0, 5'd0,  32'sd0},          1'b0, 5'd0},
    '{'{CMD_SAMPLE, 32'sd5499,       1'b0, 5'd0,  32'sd0},          1'b0, 5'd0},
    '{'{CMD_SAMPLE, 32'sd31000,      1'b0, 5'd0,  32'sd0},          1'b0, 5'd0},
    '{'{CMD_WRITE,  32'sd0,          1'b0, 5'd31, 32'sh7FFFFFFF},   1'b0, 5'd0},
    '{'{CMD_SAMPLE, 32'sh7FFFFFFF,   1'b0, 5'd0,  32'sd0},          1'b0, 5'd0},
    '{'{CMD_WRITE,  32'sd0,          1'b0, 5'd0,  32'sh80000000},   1'b0, 5'd0},
    '{'{CMD_SAMPLE, 32'sh80000000,   1'b0, 5'd0,  32'sd0},          1'b0, 5'd0},
    // equal first two levels: counts up
    '{'{CMD_WRITE,  32'sd0,          1'b0, 5'd1,  32'sh80000000},   1'b0, 5'd0},
    '{'{CMD_SAMPLE, -32'sd7,         1'b0, 5'd0,  32'sd0},          1'b0, 5'd0},
    '{'{CMD_SAMPLE, 32'sd40000,      1'b0, 5'd0,  32'sd0},          1'b0, 5'd0},
    // entry 1 below entry 0: counts down
    '{'{CMD_WRITE,  32'sd0,          1'b0, 5'd0,  32'sd50},         1'b0, 5'd0},
    '{'{CMD_WRITE,  32'sd0,          1'b0, 5'd1,  -32'sd1},         1'b0, 5'd0},
    '{'{CMD_SAMPLE, 32'sd24,         1'b0, 5'd0,  32'sd0},          1'b0, 5'd0},
    '{'{CMD_SAMPLE, 32'sd25,         1'b0, 5'd0,  32'sd0},          1'b0, 5'd0},
    '{'{CMD_SAMPLE, 32'sh80000000,   1'b0, 5'd0,  32'sd0},          1'b0, 5'd0},
    // odd negative sum: midpoint -2, not -3
    '{'{CMD_WRITE,  32'sd0,          1'b0, 5'd0,  -32'sd1},         1'b0, 5'd0},
    '{'{CMD_WRITE,  32'sd0,          1'b0, 5'd1,  -32'sd4},         1'b0, 5'd0},
    '{'{CMD_SAMPLE, -32'sd2,         1'b0, 5'd0,  32'sd0},          1'b0, 5'd0},
    '{'{CMD_SAMPLE, -32'sd3,         1'b0, 5'd0,  32'sd0},          1'b0, 5'd0},
    '{'{CMD_SAMPLE, 32'shFFFFFFFF,   1'b1, 5'd31, 32'shFFFFFFFF},   1'b0, 5'd0},
    '{'{CMD_SAMPLE, 32'sh7FFFFFFF,   1'b0, 5'd0,  32'sd0},          1'b0, 5'd0}
  };

  floor_t top_list [8] = '{5'd31, 5'd0, 5'd15, 5'd31, 5'd1, 5'd30, 5'd31, 5'd7};

  // result side: check each taken item, then draw a fresh stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (due.size() == 0) begin
          $error("floor: expected none, got %0d", out_floor);
          n_bad++;
        end else begin
          exp_f = due.pop_front();
          if (out_floor !== exp_f) begin
            $error("floor: expected %0d, got %0d", exp_f, out_floor);
            n_bad++;
          end
          if (out_selector_code !== {exp_f, 1'b0}) begin
            $error("selector_code: expected %0d, got %0d", {exp_f, 1'b0}, out_selector_code);
            n_bad++;
          end
        end
        hold_left = calm ? 0 : $urandom_range(0, 9);
        if (hold_left != 0) out_stall <= 1'b1;
      end else if (out_stall) begin
        hold_left--;
        if (hold_left <= 0) out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    item_t it;
    lv_style_t style;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every sample reads only written entries: fill the table first
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      it.cmd   = CMD_WRITE;
      it.pos   = '0;
      it.learn = 1'b0;
      it.idx   = i[4:0];
      it.epos  = i * 1000;
      push_item(it, 1'b0, '0);
    end
    foreach (plan[i]) push_item(plan[i].it, plan[i].pinned, plan[i].pin);

    // random phases, each with its own top floor and table shape
    for (int ph = 0; ph < 8; ph++) begin
      set_top_floor((ph == 3 || ph == 7) ? floor_t'($urandom_range(0, 31)) : top_list[ph]);
      calm = (ph == 2 || ph == 5);
      style = lv_style_t'(ph < 6 ? ph : $urandom_range(0, 5));
      load_levels(style);
      repeat (PHASE_ITEMS) random_item();
    end
    calm = 1'b0;

    settle();
    if (n_bad == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
